// File: rtl/core/fuls_pkg.sv
// Shared types, step codes and the control program of the first unique letter stream.
package fuls_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned StepW   = 3;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepWait  = 3'd0;
  localparam step_t StepCount = 3'd1;
  localparam step_t StepRead  = 3'd2;
  localparam step_t StepCheck = 3'd3;
  localparam step_t StepEmit  = 3'd4;

  typedef enum logic [2:0] {
    CondAlways,
    CondInValid,
    CondFillZero,
    CondPop,
    CondOutFree
  } cond_e;

  typedef struct packed {
    logic capture;
    logic count;
    logic read_q;
    logic check;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic fill_zero;
    logic pop_ok;
    logic out_free;
  } stat_t;

  typedef struct packed {
    ctrl_t ops;
    cond_e cond;
    step_t jump_true;
    step_t jump_false;
  } uword_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    unique case (step)
      StepWait: begin
        w.ops.capture = 1'b1;
        w.cond        = CondInValid;
        w.jump_true   = StepCount;
        w.jump_false  = StepWait;
      end
      StepCount: begin
        w.ops.count  = 1'b1;
        w.cond       = CondAlways;
        w.jump_true  = StepRead;
        w.jump_false = StepRead;
      end
      StepRead: begin
        w.ops.read_q = 1'b1;
        w.cond       = CondFillZero;
        w.jump_true  = StepEmit;
        w.jump_false = StepCheck;
      end
      StepCheck: begin
        w.ops.check  = 1'b1;
        w.cond       = CondPop;
        w.jump_true  = StepRead;
        w.jump_false = StepEmit;
      end
      StepEmit: begin
        w.ops.emit   = 1'b1;
        w.cond       = CondOutFree;
        w.jump_true  = StepWait;
        w.jump_false = StepEmit;
      end
      default: begin
        w.cond       = CondAlways;
        w.jump_true  = StepWait;
        w.jump_false = StepWait;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/fuls_useq.sv
// Microcoded sequencer: step counter, control program lookup and conditional jumps.
module fuls_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  fuls_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output fuls_pkg::ctrl_t ctrl_o
);
  import fuls_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   cond_hit;

  always_comb begin
    word = ucode(step_q);
    case (word.cond)
      CondAlways:   cond_hit = 1'b1;
      CondInValid:  cond_hit = in_valid_i;
      CondFillZero: cond_hit = stat_i.fill_zero;
      CondPop:      cond_hit = stat_i.pop_ok;
      CondOutFree:  cond_hit = stat_i.out_free;
      default:      cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? word.jump_true : word.jump_false;

    ctrl_o         = word.ops;
    ctrl_o.capture = word.ops.capture & in_valid_i;
    ctrl_o.check   = word.ops.check & stat_i.pop_ok;
    ctrl_o.emit    = word.ops.emit & stat_i.out_free;
    in_ready_o     = word.ops.capture;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/core/fuls_datapath.sv
// Datapath with count flops, candidate queue memory, pointers and the output register.
module fuls_datapath #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fuls_pkg::ctrl_t                 ctrl_i,
  input  logic [fuls_pkg::LetterW-1:0]    letter_i,
  input  logic                            is_last_i,
  input  logic                            out_ready_i,
  output fuls_pkg::stat_t                 stat_o,
  output logic                            out_valid_o,
  output logic [fuls_pkg::LetterW-1:0]    first_unique_o,
  output logic                            found_o,
  output logic                            string_end_o
);
  import fuls_pkg::*;

  localparam int unsigned IdxW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned FillW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(ALPHABET_SIZE - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(ALPHABET_SIZE);
  localparam logic [8:0]       AlphaLim = 9'(ALPHABET_SIZE);

  logic [1:0]         cnt_q [ALPHABET_SIZE];
  logic [LetterW-1:0] queue_mem [ALPHABET_SIZE];
  logic [LetterW-1:0] front_q;
  logic [LetterW-1:0] letter_q;
  logic               last_q;
  logic [IdxW-1:0]    head_q, tail_q;
  logic [FillW-1:0]   fill_q;
  logic               out_valid_q;
  logic [LetterW-1:0] out_letter_q;
  logic               out_found_q, out_last_q;

  logic [LetterW-1:0] addr;
  logic [IdxW-1:0]    addr_idx;
  logic               addr_ok;
  logic [1:0]         cnt_rd;
  logic               push;
  logic               clear;
  logic               out_free;

  always_comb begin
    addr     = ctrl_i.count ? letter_q : front_q;
    addr_ok  = ({4'b0, addr} < AlphaLim);
    addr_idx = IdxW'(addr);
    cnt_rd   = addr_ok ? cnt_q[addr_idx] : 2'd0;
    push     = ctrl_i.count && addr_ok && (cnt_rd == 2'd0) && (fill_q < FullFill);
    out_free = !out_valid_q || out_ready_i;
    clear    = ctrl_i.emit && last_q;

    stat_o.fill_zero = (fill_q == '0);
    stat_o.pop_ok    = (fill_q != '0) && addr_ok && (cnt_rd > 2'd1);
    stat_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        cnt_q[i] <= 2'd0;
      end
    end else if (clear) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        cnt_q[i] <= 2'd0;
      end
    end else if (ctrl_i.count && addr_ok && (cnt_rd != 2'd2)) begin
      cnt_q[addr_idx] <= cnt_rd + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail_q] <= letter_q;
    end
    if (ctrl_i.read_q) begin
      front_q <= queue_mem[head_q];
    end
    if (ctrl_i.capture) begin
      letter_q <= letter_i;
      last_q   <= is_last_i;
    end
    if (ctrl_i.emit) begin
      out_letter_q <= (fill_q != '0) ? front_q : '0;
      out_found_q  <= (fill_q != '0);
      out_last_q   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear) begin
        head_q <= '0;
        tail_q <= '0;
        fill_q <= '0;
      end else if (push) begin
        tail_q <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
        fill_q <= fill_q + 1'b1;
      end else if (ctrl_i.check) begin
        head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
        fill_q <= fill_q - 1'b1;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_unique_o = out_letter_q;
  assign found_o        = out_found_q;
  assign string_end_o   = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill) else $error("Candidate fill exceeds the alphabet size.");
  a_empty_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q)) else $error("Empty queue with split pointers.");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (fill_q == '0) && (head_q == '0))
    else $error("String end did not clear the queue.");
  a_found_has_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |=> (out_found_q == $past(fill_q != '0)))
    else $error("Emit found flag disagrees with queue fill.");

endmodule

// File: rtl/core/first_unique_letter_stream_top.sv
// Top level of the first unique letter stream: microcoded sequencer plus datapath.
// Each input transaction runs through the wait, count and read steps; while the queue is not
// empty a check step follows each read, popping a candidate seen more than once and reading
// again, and the transaction ends in the emit step, so only one transaction is in flight.
// A new input transaction is taken while the previous result waits in the output register.
// Reset clears counts, queue pointers, sequencer and output valid; queue memory is not cleared.
module first_unique_letter_stream_top #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] letter, [7:5] zero
  input  logic       s_axis_tlast_i,   // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] first_unique, [7:5] zero
  output logic       m_axis_tuser_o,   // found
  output logic       m_axis_tlast_o    // string_end
);
  import fuls_pkg::*;

  ctrl_t              ctrl;
  stat_t              stat;
  logic [LetterW-1:0] first_unique;

  fuls_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  fuls_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .letter_i       (s_axis_tdata_i[LetterW-1:0]),
    .is_last_i      (s_axis_tlast_i),
    .out_ready_i    (m_axis_tready_i),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid_o),
    .first_unique_o (first_unique),
    .found_o        (m_axis_tuser_o),
    .string_end_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, first_unique};

endmodule

// File: dv/first_unique_letter_stream_top_tb.sv
// Self-checking stream testbench for the first unique letter stream with a built-in predictor.
module first_unique_letter_stream_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Alphabet  = 26;
  localparam int unsigned StallMax  = 1000;
  localparam int unsigned LiveGoal  = 1150;
  localparam int unsigned DrainWait = 100;

  typedef struct packed {
    logic [4:0] letter;
    logic       is_last;
  } letter_item_t;

  typedef struct packed {
    logic [4:0] letter;
    logic       found;
    logic       string_end;
  } answer_t;

  logic       clk_i   = 1'b0;
  logic       rst_ni  = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  letter_item_t letter_items[$];
  answer_t      answer_q[$];
  logic [1:0]   seen_cnt[Alphabet];
  logic [4:0]   cand_q[$];

  int  live_items = 0;
  int  err_cnt    = 0;
  int  stall_cnt  = 0;
  int  drv_gap    = 0;
  int  rdy_hold   = 0;
  bit  drv_busy   = 1'b0;
  bit  in_fire    = 1'b0;
  bit  quiet_in   = 1'b0;
  bit  quiet_out  = 1'b0;

  first_unique_letter_stream_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    foreach (seen_cnt[i]) seen_cnt[i] = 2'd0;
  end

  function automatic answer_t next_answer(input logic [4:0] code, input logic last);
    answer_t ans;
    if (code < Alphabet) begin
      if (seen_cnt[code] == 2'd0 && cand_q.size() < Alphabet) cand_q = {cand_q, code};
      if (seen_cnt[code] < 2'd2) seen_cnt[code] = seen_cnt[code] + 2'd1;
    end
    while (cand_q.size() > 0 && seen_cnt[cand_q[0]] > 2'd1) void'(cand_q.pop_front());
    ans.found      = (cand_q.size() > 0);
    ans.letter     = ans.found ? cand_q[0] : 5'd0;
    ans.string_end = last;
    if (last) begin
      foreach (seen_cnt[i]) seen_cnt[i] = 2'd0;
      cand_q.delete();
    end
    return ans;
  endfunction

  function automatic int idle_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put(input int code, input bit last);
    letter_item_t it;
    it.letter  = code[4:0];
    it.is_last = last;
    letter_items = {letter_items, it};
    if (code < Alphabet) live_items++;
  endtask

  always @(negedge clk_i) begin : drive
    letter_item_t nxt;
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) quiet_in = !quiet_in;
      if ($urandom_range(0, 199) == 0) quiet_out = !quiet_out;
      if (drv_busy && in_fire) begin
        drv_busy = 1'b0;
        drv_gap  = idle_len(quiet_in);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (letter_items.size() > 0) begin
          nxt = letter_items.pop_front();
          s_tdata  <= {3'b000, nxt.letter};
          s_tlast  <= nxt.is_last;
          drv_busy = 1'b1;
        end
      end
      s_valid <= drv_busy;
      if (rdy_hold > 0) begin
        m_ready <= 1'b0;
        rdy_hold--;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rdy_hold = idle_len(quiet_out);
      end
    end
  end

  always @(posedge clk_i) begin : watch
    answer_t want;
    bit      fire_s;
    bit      fire_m;
    fire_s = s_valid && s_axis_tready_o;
    fire_m = m_axis_tvalid_o && m_ready;
    in_fire <= fire_s;
    if (fire_s) answer_q = {answer_q, next_answer(s_tdata[4:0], s_tlast)};
    if (fire_m) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result transaction: first_unique=%0d found=%0b string_end=%0b",
               m_axis_tdata_o[4:0], m_axis_tuser_o, m_axis_tlast_o);
        err_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata_o[4:0] !== want.letter) begin
          $error("first_unique: expected %0d, got %0d", want.letter, m_axis_tdata_o[4:0]);
          err_cnt++;
        end
        if (m_axis_tuser_o !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_axis_tuser_o);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.string_end) begin
          $error("string_end: expected %0b, got %0b", want.string_end, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
    if (fire_s || fire_m) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= StallMax) begin
        $display("** first_unique_letter_stream_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int k;
    int base;
    int n;
    int j;
    int tmp;
    bit rev;
    int perm[Alphabet];

    put(0, 1);
    put(25, 1);
    put(31, 1);
    put(26, 0); put(0, 0); put(0, 0); put(1, 1);
    put(0, 0); put(1, 0); put(2, 0); put(0, 0); put(1, 0); put(2, 1);
    put(30, 0); put(5, 0); put(27, 0); put(5, 1);
    put(7, 0); put(7, 0); put(7, 1);
    put(16, 0); put(8, 1);

    while (live_items < LiveGoal) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        k    = $urandom_range(2, 6);
        base = $urandom_range(0, Alphabet - k);
        len  = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) put(base + $urandom_range(0, k - 1), i == len - 1);
      end else if (kind < 65) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) put($urandom_range(0, Alphabet - 1), i == len - 1);
      end else if (kind < 75) begin
        for (int i = 0; i < Alphabet; i++) perm[i] = i;
        for (int i = Alphabet - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        n   = $urandom_range(0, Alphabet);
        rev = $urandom_range(0, 1);
        for (int i = 0; i < Alphabet; i++) put(perm[i], n == 0 && i == Alphabet - 1);
        for (int i = 0; i < n; i++) put(perm[rev ? n - 1 - i : i], i == n - 1);
      end else if (kind < 90) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) put($urandom_range(0, 31), i == len - 1);
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) put($urandom_range(0, 31), i == len - 1);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (letter_items.size() > 0 || drv_busy) @(posedge clk_i);
    while (answer_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** first_unique_letter_stream_top: PASSED **");
    end else begin
      $display("** first_unique_letter_stream_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fuls_pkg.sv
rtl/core/fuls_useq.sv
rtl/core/fuls_datapath.sv
rtl/core/first_unique_letter_stream_top.sv
dv/first_unique_letter_stream_top_tb.sv
